@@ rtl/rdc_pkg.sv @@
// Shared types and constants of the reliable datagram channel.
package rdc_pkg;

   typedef enum logic [1:0] {
      OP_RECEIVE    = 2'd0,
      OP_QUEUE      = 2'd1,
      OP_SEND_UNREL = 2'd2,
      OP_TICK       = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ACT_NONE          = 3'd0,
      ACT_SEND_FRAG     = 3'd1,
      ACT_SEND_ACK      = 3'd2,
      ACT_SEND_UNREL    = 3'd3,
      ACT_DELIVER_UNREL = 3'd4,
      ACT_STORE         = 3'd5
   } action_type;

   localparam logic [1:0] CSR_MSS       = 2'd0;
   localparam logic [1:0] CSR_QUEUE_LIM = 2'd1;
   localparam logic [1:0] CSR_RETX      = 2'd2;

   localparam logic [31:0] HDR_BYTES = 32'd8;
   localparam logic [31:0] F_DATA    = 32'h0001_0000;
   localparam logic [31:0] F_ACK     = 32'h0002_0000;
   localparam logic [31:0] F_EOM     = 32'h0008_0000;
   localparam logic [31:0] F_UNREL   = 32'h0010_0000;
   localparam logic [31:0] F_CTL     = 32'h8000_0000;

   typedef struct packed {
      action_type   action;
      logic [31:0]  hdr;
      logic [31:0]  seq;
      logic [12:0]  off;
      logic [13:0]  len;
      logic         done;
   } res_type;

endpackage

@@ rtl/rdc_len_ram.sv @@
// Message length store: one write port, one registered read port.
module rdc_len_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int DW    = 14
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/reliable_datagram_channel_unit.sv @@
// Top level of the stop-and-wait reliable datagram channel engine.
//
// req_ channel: one word per item; tuser is the operation (receive header,
// queue reliable message, send unreliable, tick), tdata the header word,
// sequence word and item length. rsp_ channel: one or two result words per
// item, tuser is the action, tlast marks the item's final result.
// csr_ channel: register writes, taken at once; the user must write only
// while idle, which the block does not enforce. An accepted item executes
// in the next cycle, once the result buffer is empty; its results are
// visible the cycle after. A new item is accepted only after the last has
// executed; each extra result delays the next. This pacing is set by the
// length store's registered read, which must see the previous item's state.
// Reset clears all sequence counters, the queue and the result buffer.
// When the receiver stalls, results hold in the buffer; one more item is
// accepted and then waits for the buffer to drain.
module reliable_datagram_channel_unit #(
   parameter int QUEUE_DEPTH      = 16,
   parameter int WIRE_PAYLOAD_MAX = 1024,
   parameter int MESSAGE_MAX      = 8192,
   parameter int REASSEMBLY_BYTES = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // header_word, sequence_word, item_length
   input  logic [1:0]  req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_header, out_sequence, data_offset, data_length, message_complete,
   // accepted, zero pad
   output logic [95:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,   // action
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_wdata
);

   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int LW = $clog2(MESSAGE_MAX + 1);
   localparam int RW = $clog2(REASSEMBLY_BYTES + 1);
   localparam logic [QW-1:0] LAST_IDX = QW'(QUEUE_DEPTH - 1);

   // configuration
   logic [10:0] mss_ff, mss_in;
   logic [19:0] qlim_ff, qlim_in;
   logic [15:0] retx_ff, retx_in;

   // channel state
   logic [QW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [LW-1:0] hlen_ff, hlen_in;
   logic [19:0]   queued_ff, queued_in;
   logic [LW-1:0] soff_ff, soff_in;
   logic [10:0]   flen_ff, flen_in;
   logic          fwait_ff, fwait_in;
   logic [31:0]   fseq_ff, fseq_in;
   logic [31:0]   sseq_ff, sseq_in;
   logic [31:0]   useq_ff, useq_in;
   logic [31:0]   urseq_ff, urseq_in;
   logic [31:0]   rseq_ff, rseq_in;
   logic [RW-1:0] rlen_ff, rlen_in;
   logic          disc_ff, disc_in;
   logic [15:0]   ticks_ff, ticks_in;

   // input stage
   logic                stage_ff, stage_in;
   rdc_pkg::op_type     op_ff;
   logic [31:0]         ihdr_ff;
   logic [31:0]         iseq_ff;
   logic [15:0]         ilen_ff;

   // result buffer
   rdc_pkg::res_type    slot_ff [2];
   rdc_pkg::res_type    slot_in [2];
   logic [1:0]          ocnt_ff, ocnt_in;
   logic                acc_ff, acc_in;

   // length store
   logic          ram_we;
   logic [QW-1:0] ram_waddr;
   logic [QW-1:0] head_nxt;
   logic [LW-1:0] ram_rdata;

   logic req_fire, rsp_fire, exec;

   assign req_tready = !stage_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign exec       = stage_ff && (ocnt_ff == 2'd0);
   assign csr_ready  = 1'b1;
   assign head_nxt   = (head_ff == LAST_IDX) ? '0 : head_ff + QW'(1);

   rdc_len_ram #(
      .DEPTH (QUEUE_DEPTH),
      .AW    (QW),
      .DW    (LW)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (LW'(ilen_ff)),
      .rd_addr (head_nxt),
      .rd_data (ram_rdata)
   );

   always_comb begin
      mss_in  = mss_ff;
      qlim_in = qlim_ff;
      retx_in = retx_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rdc_pkg::CSR_MSS:       mss_in  = csr_wdata[10:0];
            rdc_pkg::CSR_QUEUE_LIM: qlim_in = csr_wdata;
            rdc_pkg::CSR_RETX:      retx_in = csr_wdata[15:0];
            default:                ;
         endcase
      end
   end

   // item execution
   logic [10:0]   eff_mss;
   logic [15:0]   pay;
   logic [15:0]   hflags;
   logic          bad_pkt;
   logic [LW:0]   ack_sum;
   logic [CW-1:0] cnt_a;
   logic [LW-1:0] hlen_a;
   logic [LW-1:0] soff_a;
   logic          fwait_a;
   logic          want_send;
   logic [LW-1:0] remain;
   logic [10:0]   fl_new;
   logic          eom_new;
   logic          eom_in;
   logic [17:0]   room;
   logic [20:0]   q_sum;
   logic [CW:0]   tail_sum;
   logic [15:0]   ticks_n;
   logic [1:0]    n;
   logic          ok;
   rdc_pkg::res_type res [2];

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      hlen_in   = hlen_ff;
      queued_in = queued_ff;
      soff_in   = soff_ff;
      flen_in   = flen_ff;
      fwait_in  = fwait_ff;
      fseq_in   = fseq_ff;
      sseq_in   = sseq_ff;
      useq_in   = useq_ff;
      urseq_in  = urseq_ff;
      rseq_in   = rseq_ff;
      rlen_in   = rlen_ff;
      disc_in   = disc_ff;
      ticks_in  = ticks_ff;
      ram_we    = 1'b0;
      res[0]    = '0;
      res[1]    = '0;
      n         = 2'd0;
      ok        = 1'b0;
      want_send = 1'b0;
      cnt_a     = count_ff;
      hlen_a    = hlen_ff;
      soff_a    = soff_ff;
      fwait_a   = fwait_ff;
      remain    = '0;
      fl_new    = '0;
      eom_new   = 1'b0;
      ack_sum   = (LW+1)'(soff_ff) + (LW+1)'(flen_ff);

      if (mss_ff == 11'd0) begin
         eff_mss = 11'd1;
      end else if (32'(mss_ff) > 32'(WIRE_PAYLOAD_MAX)) begin
         eff_mss = 11'(WIRE_PAYLOAD_MAX);
      end else begin
         eff_mss = mss_ff;
      end

      pay      = ilen_ff - 16'(rdc_pkg::HDR_BYTES);
      hflags   = ihdr_ff[31:16];
      bad_pkt  = (ilen_ff < 16'(rdc_pkg::HDR_BYTES)) || (ihdr_ff[15:0] != ilen_ff) ||
                 ihdr_ff[31];
      eom_in   = ihdr_ff[19];
      room     = 18'(REASSEMBLY_BYTES) - 18'(rlen_ff);
      q_sum    = 21'(queued_ff) + 21'(ilen_ff);
      tail_sum = (CW+1)'(head_ff) + (CW+1)'(count_ff);
      if (tail_sum >= (CW+1)'(QUEUE_DEPTH)) begin
         tail_sum = tail_sum - (CW+1)'(QUEUE_DEPTH);
      end
      ram_waddr = QW'(tail_sum);
      ticks_n   = (ticks_ff == 16'hFFFF) ? ticks_ff : ticks_ff + 16'd1;

      if (exec) begin
         unique case (op_ff)
            rdc_pkg::OP_RECEIVE: begin
               if (!bad_pkt) begin
                  if (ihdr_ff[17]) begin
                     if (hflags == 16'h0002 && pay == 16'd0) begin
                        ok = 1'b1;
                        if (fwait_ff && iseq_ff == fseq_ff) begin
                           fwait_a   = 1'b0;
                           soff_a    = LW'(ack_sum);
                           want_send = 1'b1;
                           if (count_ff != '0 && ack_sum == (LW+1)'(hlen_ff)) begin
                              queued_in = queued_ff - 20'(hlen_ff);
                              head_in   = head_nxt;
                              cnt_a     = count_ff - CW'(1);
                              soff_a    = '0;
                              hlen_a    = ram_rdata;
                           end
                        end
                     end
                  end else if (ihdr_ff[20]) begin
                     if (hflags == 16'h0010 && 32'(pay) <= 32'(WIRE_PAYLOAD_MAX)) begin
                        ok = 1'b1;
                        if (iseq_ff >= urseq_ff) begin
                           urseq_in = iseq_ff + 32'd1;
                           res[0]   = '{rdc_pkg::ACT_DELIVER_UNREL, 32'd0, iseq_ff,
                                        13'd0, pay[13:0], 1'b0};
                           n        = 2'd1;
                        end
                     end
                  end else if (ihdr_ff[16] && (hflags & 16'hFFF6) == 16'd0) begin
                     res[0] = '{rdc_pkg::ACT_SEND_ACK,
                                rdc_pkg::F_ACK + rdc_pkg::HDR_BYTES, iseq_ff,
                                13'd0, 14'd0, 1'b0};
                     n  = 2'd1;
                     ok = 1'b1;
                     if (iseq_ff == rseq_ff) begin
                        rseq_in = rseq_ff + 32'd1;
                        if (disc_ff) begin
                           if (eom_in) begin
                              disc_in = 1'b0;
                           end
                        end else if (18'(pay) > room) begin
                           rlen_in = '0;
                           disc_in = !eom_in;
                           ok      = 1'b0;
                        end else begin
                           res[1]  = '{rdc_pkg::ACT_STORE, 32'd0, iseq_ff,
                                       13'(rlen_ff), pay[13:0], eom_in};
                           n       = 2'd2;
                           rlen_in = eom_in ? '0 : RW'(18'(rlen_ff) + 18'(pay));
                        end
                     end
                  end
               end
            end
            rdc_pkg::OP_QUEUE: begin
               if (ilen_ff != 16'd0 && 32'(ilen_ff) <= 32'(MESSAGE_MAX) &&
                   32'(count_ff) < 32'(QUEUE_DEPTH) && q_sum <= 21'(qlim_ff)) begin
                  ok        = 1'b1;
                  ram_we    = 1'b1;
                  queued_in = 20'(q_sum);
                  cnt_a     = count_ff + CW'(1);
                  if (count_ff == '0) begin
                     hlen_a = LW'(ilen_ff);
                  end
                  want_send = 1'b1;
               end
            end
            rdc_pkg::OP_SEND_UNREL: begin
               if (ilen_ff != 16'd0 && ilen_ff <= 16'(eff_mss)) begin
                  ok      = 1'b1;
                  res[0]  = '{rdc_pkg::ACT_SEND_UNREL,
                              rdc_pkg::F_UNREL + rdc_pkg::HDR_BYTES + 32'(ilen_ff),
                              useq_ff, 13'd0, ilen_ff[13:0], 1'b0};
                  n       = 2'd1;
                  useq_in = useq_ff + 32'd1;
               end
            end
            rdc_pkg::OP_TICK: begin
               if (!fwait_ff) begin
                  want_send = 1'b1;
               end else begin
                  ticks_in = ticks_n;
                  if (ticks_n >= retx_ff && count_ff != '0) begin
                     ticks_in = 16'd0;
                     res[0]   = '{rdc_pkg::ACT_SEND_FRAG,
                                  (ack_sum == (LW+1)'(hlen_ff) ?
                                   rdc_pkg::F_DATA | rdc_pkg::F_EOM : rdc_pkg::F_DATA) +
                                  rdc_pkg::HDR_BYTES + 32'(flen_ff),
                                  fseq_ff, 13'(soff_ff), 14'(flen_ff), 1'b0};
                     n        = 2'd1;
                  end
               end
            end
            default: ;
         endcase

         // start the next fragment of the head message
         if (want_send && cnt_a != '0 && !fwait_a) begin
            remain   = (hlen_a > soff_a) ? hlen_a - soff_a : '0;
            fl_new   = (32'(remain) < 32'(eff_mss)) ? 11'(remain) : eff_mss;
            eom_new  = (LW'(fl_new) == remain);
            flen_in  = fl_new;
            fseq_in  = sseq_ff;
            sseq_in  = sseq_ff + 32'd1;
            ticks_in = 16'd0;
            fwait_a  = 1'b1;
            res[n[0]] = '{rdc_pkg::ACT_SEND_FRAG,
                          (eom_new ? rdc_pkg::F_DATA | rdc_pkg::F_EOM : rdc_pkg::F_DATA) +
                          rdc_pkg::HDR_BYTES + 32'(fl_new),
                          sseq_ff, 13'(soff_a), 14'(fl_new), 1'b0};
            n = n + 2'd1;
         end
         if (n == 2'd0) begin
            n = 2'd1;
         end
         count_in = cnt_a;
         hlen_in  = hlen_a;
         soff_in  = soff_a;
         fwait_in = fwait_a;
      end
   end

   always_comb begin
      stage_in   = stage_ff;
      ocnt_in    = ocnt_ff;
      acc_in     = acc_ff;
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      if (exec) begin
         stage_in   = 1'b0;
         ocnt_in    = n;
         acc_in     = ok;
         slot_in[0] = res[0];
         slot_in[1] = res[1];
      end else if (rsp_fire) begin
         ocnt_in    = ocnt_ff - 2'd1;
         slot_in[0] = slot_ff[1];
      end
      if (req_fire) begin
         stage_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mss_ff    <= 11'd1024;
         qlim_ff   <= 20'd524288;
         retx_ff   <= 16'd1000;
         head_ff   <= '0;
         count_ff  <= '0;
         queued_ff <= '0;
         soff_ff   <= '0;
         flen_ff   <= '0;
         fwait_ff  <= 1'b0;
         fseq_ff   <= '0;
         sseq_ff   <= '0;
         useq_ff   <= '0;
         urseq_ff  <= '0;
         rseq_ff   <= '0;
         rlen_ff   <= '0;
         disc_ff   <= 1'b0;
         ticks_ff  <= '0;
         stage_ff  <= 1'b0;
         ocnt_ff   <= '0;
      end else begin
         mss_ff    <= mss_in;
         qlim_ff   <= qlim_in;
         retx_ff   <= retx_in;
         head_ff   <= head_in;
         count_ff  <= count_in;
         queued_ff <= queued_in;
         soff_ff   <= soff_in;
         flen_ff   <= flen_in;
         fwait_ff  <= fwait_in;
         fseq_ff   <= fseq_in;
         sseq_ff   <= sseq_in;
         useq_ff   <= useq_in;
         urseq_ff  <= urseq_in;
         rseq_ff   <= rseq_in;
         rlen_ff   <= rlen_in;
         disc_ff   <= disc_in;
         ticks_ff  <= ticks_in;
         stage_ff  <= stage_in;
         ocnt_ff   <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      hlen_ff    <= hlen_in;
      acc_ff     <= acc_in;
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
      if (req_fire) begin
         op_ff   <= rdc_pkg::op_type'(req_tuser);
         ihdr_ff <= req_tdata[31:0];
         iseq_ff <= req_tdata[63:32];
         ilen_ff <= req_tdata[79:64];
      end
   end

   assign rsp_tvalid = (ocnt_ff != 2'd0);
   assign rsp_tlast  = (ocnt_ff == 2'd1);
   assign rsp_tuser  = slot_ff[0].action;
   assign rsp_tdata  = {3'd0, acc_ff, slot_ff[0].done, slot_ff[0].len, slot_ff[0].off,
                        slot_ff[0].seq, slot_ff[0].hdr};

endmodule

@@ rtl/rdc_checker.sv @@
// Port-level checks of the reliable datagram channel, bound to the top level.
module rdc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word taken while one is pending");

   a_ack_header: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == rdc_pkg::ACT_SEND_ACK |->
      rsp_tdata[31:0] == rdc_pkg::F_ACK + rdc_pkg::HDR_BYTES)
      else $error("ack carries wrong header");

   a_none_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == rdc_pkg::ACT_NONE |-> rsp_tlast)
      else $error("empty result is not the last of its item");

endmodule

bind reliable_datagram_channel_unit rdc_checker u_rdc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
